// ===== hw/rtl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// shared types and constants of the huffman code bit packer
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int OPCODE_W   = 2;
  localparam int SYMBOL_W   = 8;
  localparam int CODE_W     = 20;
  localparam int LEN_W      = 5;
  localparam int BYTE_W     = 8;
  localparam int PAD_W      = 3;
  localparam int TABLE_DEPTH = 256;

  localparam int MAX_CODE_LEN = 20;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // pending bits plus the longest code
  localparam int ACC_W = 7 + CODE_W;
  localparam int CNT_W = 5;

  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } code_entry_t;

  typedef struct packed {
    logic                wr_en;
    logic [SYMBOL_W-1:0] sym;
    logic                rd_en;
  } table_ctl_t;

endpackage

// ===== hw/rtl/hcbp_if.sv =====
// ----------------------------------------------------------------------------
// hcbp_if
// valid/ready channels for commands and packed results
// ----------------------------------------------------------------------------
interface hcbp_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [hcbp_pkg::OPCODE_W-1:0]  opcode;
  logic [hcbp_pkg::SYMBOL_W-1:0]  symbol;
  logic [hcbp_pkg::CODE_W-1:0]    code_bits;
  logic [hcbp_pkg::LEN_W-1:0]     code_length;

  modport source (output valid, opcode, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, opcode, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_res_if;
  logic                         valid;
  logic                         ready;
  logic [hcbp_pkg::BYTE_W-1:0]  out_byte;
  logic                         byte_valid;
  logic [hcbp_pkg::PAD_W-1:0]   pad_bits;
  logic                         error;
  logic                         last;

  modport source (output valid, out_byte, byte_valid, pad_bits, error, last, input ready);
  modport sink   (input valid, out_byte, byte_valid, pad_bits, error, last, output ready);
endinterface

// ===== hw/rtl/hcbp_code_table.sv =====
// ----------------------------------------------------------------------------
// hcbp_code_table
// per-symbol code memory: checks and masks loads, registered read
// ----------------------------------------------------------------------------
module hcbp_code_table (
  input  logic                          clk,
  input  hcbp_pkg::table_ctl_t          ctl,
  input  logic [hcbp_pkg::CODE_W-1:0]   code_bits,
  input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
  output logic                          len_error,
  output hcbp_pkg::code_entry_t         rd_entry
);

  hcbp_pkg::code_entry_t mem [hcbp_pkg::TABLE_DEPTH];
  logic [hcbp_pkg::CODE_W:0] mask_wide;
  hcbp_pkg::code_entry_t     wr_entry;

  assign len_error = (code_length > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT));

  always_comb begin
    mask_wide     = ((hcbp_pkg::CODE_W+1)'(1) << code_length) - (hcbp_pkg::CODE_W+1)'(1);
    wr_entry.len  = code_length;
    wr_entry.code = code_bits & mask_wide[hcbp_pkg::CODE_W-1:0];
  end

  // rejected loads leave the entry unchanged
  always_ff @(posedge clk) begin
    if (ctl.wr_en && !len_error) begin
      mem[ctl.sym] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_entry <= mem[ctl.sym];
    end
  end

endmodule

// ===== hw/rtl/huffman_code_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// huffman encoder back end: code table lookup and msb-first byte packing
// ----------------------------------------------------------------------------
// an item passes the table lookup stage and then the result register before
//   its first result is offered
// throughput: one item per cycle while each item gives at most one result
//   and res.ready is high; an item with k results holds the result register
//   until all k transfer; table read and single result register set the rate
// reset clears pending bits and all valid flags; table entries are undefined
//   until loaded
module huffman_code_bit_packer_unit (
  input  logic       clk,
  input  logic       rst,
  hcbp_cmd_if.sink   cmd,
  hcbp_res_if.source res
);

  localparam int AW = hcbp_pkg::ACC_W;
  localparam int CW = hcbp_pkg::CNT_W;

  // lookup stage
  logic                            s1_valid;
  logic [hcbp_pkg::OPCODE_W-1:0]   s1_op;
  logic                            s1_err;
  logic                            s1_go;
  hcbp_pkg::code_entry_t           rd_entry;
  hcbp_pkg::table_ctl_t            tctl;
  logic                            len_error;

  // pending partial byte
  logic [6:0] pend_bits, pend_bits_next;
  logic [2:0] pend_cnt, pend_cnt_next;

  // result register, drained one result per cycle while res.ready is high
  logic       job_valid;
  logic [7:0] job_bytes [3];
  logic       job_bv;
  logic [2:0] job_pad;
  logic       job_err;
  logic [1:0] job_cnt;
  logic [1:0] job_idx;
  logic       job_last;
  logic       job_done;
  logic       job_free;

  // next job from the lookup stage
  logic       new_job;
  logic [7:0] new_bytes [3];
  logic       new_bv;
  logic [2:0] new_pad;
  logic       new_err;
  logic [1:0] new_cnt;

  logic [AW-1:0] acc;
  logic [AW-1:0] aligned;
  logic [CW-1:0] nbits;

  logic cmd_xfer;

  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign job_last  = (job_idx == job_cnt - 2'd1);
  assign job_done  = job_valid && res.ready && job_last;
  assign job_free  = !job_valid || job_done;
  assign s1_go     = s1_valid && job_free;
  assign cmd.ready = !s1_valid || s1_go;

  assign tctl.wr_en = cmd_xfer && (cmd.opcode == hcbp_pkg::OP_LOAD);
  assign tctl.rd_en = cmd_xfer && (cmd.opcode == hcbp_pkg::OP_ENCODE);
  assign tctl.sym   = cmd.symbol;

  hcbp_code_table u_table (
    .clk         (clk),
    .ctl         (tctl),
    .code_bits   (cmd.code_bits),
    .code_length (cmd.code_length),
    .len_error   (len_error),
    .rd_entry    (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      s1_op  <= cmd.opcode;
      s1_err <= len_error;
    end
  end

  always_comb begin
    acc     = (AW'(pend_bits) << rd_entry.len) | AW'(rd_entry.code);
    nbits   = CW'(pend_cnt) + rd_entry.len;
    // left-align so completed bytes sit at fixed places
    aligned = acc << (CW'(AW) - nbits);

    new_job        = 1'b0;
    new_bytes[0]   = 8'd0;
    new_bytes[1]   = 8'd0;
    new_bytes[2]   = 8'd0;
    new_bv         = 1'b0;
    new_pad        = 3'd0;
    new_err        = 1'b0;
    new_cnt        = 2'd1;
    pend_bits_next = pend_bits;
    pend_cnt_next  = pend_cnt;

    unique case (s1_op)
      hcbp_pkg::OP_LOAD: begin
        new_job = 1'b1;
        new_err = s1_err;
      end
      hcbp_pkg::OP_ENCODE: begin
        new_job        = (nbits[CW-1:3] != 2'd0);
        new_bytes[0]   = aligned[AW-1 -: 8];
        new_bytes[1]   = aligned[AW-9 -: 8];
        new_bytes[2]   = aligned[AW-17 -: 8];
        new_bv         = 1'b1;
        new_cnt        = nbits[CW-1:3];
        pend_cnt_next  = nbits[2:0];
        pend_bits_next = acc[6:0] & ((7'd1 << nbits[2:0]) - 7'd1);
      end
      hcbp_pkg::OP_FLUSH: begin
        new_job        = 1'b1;
        new_bv         = (pend_cnt != 3'd0);
        new_bytes[0]   = (pend_cnt != 3'd0) ?
                         8'({1'b0, pend_bits} << (4'd8 - {1'b0, pend_cnt})) : 8'd0;
        new_pad        = 3'd0 - pend_cnt;
        pend_bits_next = 7'd0;
        pend_cnt_next  = 3'd0;
      end
      default: begin
        new_job = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= 7'd0;
      pend_cnt  <= 3'd0;
    end else if (s1_go) begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_idx   <= 2'd0;
    end else if (job_free) begin
      job_valid <= s1_go && new_job;
      job_idx   <= 2'd0;
    end else if (res.ready) begin
      job_idx <= job_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_free && s1_go && new_job) begin
      job_bytes <= new_bytes;
      job_bv    <= new_bv;
      job_pad   <= new_pad;
      job_err   <= new_err;
      job_cnt   <= new_cnt;
    end
  end

  assign res.valid      = job_valid;
  assign res.out_byte   = job_bytes[job_idx];
  assign res.byte_valid = job_bv;
  assign res.pad_bits   = job_pad;
  assign res.error      = job_err;
  assign res.last       = job_last;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job_idx < job_cnt))
    else $error("result index beyond result count");

  a_single_nonbyte: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_bv) |-> (job_cnt == 2'd1 && job_pad == 3'd0))
    else $error("load or empty flush with more than one result");

  a_pending_clean: assert property (@(posedge clk) disable iff (rst)
    (pend_cnt == 3'd0) |-> (pend_bits == 7'd0))
    else $error("stale pending bits with empty count");

  a_lookup_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(rd_entry) && $stable(s1_op)))
    else $error("stalled lookup stage changed");

endmodule

// ===== tb/sv/huffman_code_bit_packer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit_tb
// drives code table loads, symbol encodes, flushes and unused opcodes into
// the packer and checks every byte, byte_valid, last, pad count and error
// flag against a predictor holding its own code table and partial byte
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_unit_tb;

  // opcode the block ignores
  localparam logic [hcbp_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [hcbp_pkg::OPCODE_W-1:0] opcode;
    logic [hcbp_pkg::SYMBOL_W-1:0] symbol;
    logic [hcbp_pkg::CODE_W-1:0]   code_bits;
    logic [hcbp_pkg::LEN_W-1:0]    code_length;
  } cmd_item_t;

  typedef struct packed {
    logic [hcbp_pkg::BYTE_W-1:0] out_byte;
    logic                        byte_valid;
    logic [hcbp_pkg::PAD_W-1:0]  pad_bits;
    logic                        error;
    logic                        last;
  } packed_result_t;

  class bit_packer_predictor;
    logic [hcbp_pkg::CODE_W-1:0]   code_tbl [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::LEN_W-1:0]    len_tbl [hcbp_pkg::TABLE_DEPTH];
    bit                            loaded [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::SYMBOL_W-1:0] loaded_syms [$];
    logic [6:0]        held_bits;
    int                held_count;
    packed_result_t    expected_outputs [$];
    int                mismatches;

    function new();
      held_bits = '0;
      held_count = 0;
      mismatches = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function int pending();
      return expected_outputs.size();
    endfunction

    task note_command(input cmd_item_t c);
      packed_result_t r;
      logic [hcbp_pkg::CODE_W:0] mask;
      logic [hcbp_pkg::ACC_W-1:0] acc;
      int n;
      int first;
      r = '0;
      case (c.opcode)
        hcbp_pkg::OP_LOAD: begin
          r.last = 1'b1;
          if (c.code_length > hcbp_pkg::LEN_LIMIT) begin
            // over-long code: entry stays as it was
            r.error = 1'b1;
          end else begin
            mask = ((hcbp_pkg::CODE_W+1)'(1) << c.code_length) - 1'b1;
            code_tbl[c.symbol] = c.code_bits & mask[hcbp_pkg::CODE_W-1:0];
            len_tbl[c.symbol] = c.code_length;
            if (!loaded[c.symbol]) loaded_syms.push_back(c.symbol);
            loaded[c.symbol] = 1'b1;
          end
          expected_outputs.push_back(r);
        end
        hcbp_pkg::OP_ENCODE: begin
          acc = hcbp_pkg::ACC_W'(held_bits);
          acc = (acc << len_tbl[c.symbol]) | hcbp_pkg::ACC_W'(code_tbl[c.symbol]);
          n = held_count + int'(len_tbl[c.symbol]);
          first = expected_outputs.size();
          while (n >= 8) begin
            r = '0;
            r.out_byte = hcbp_pkg::BYTE_W'(acc >> (n - 8));
            r.byte_valid = 1'b1;
            expected_outputs.push_back(r);
            n -= 8;
          end
          if (expected_outputs.size() > first)
            expected_outputs[expected_outputs.size()-1].last = 1'b1;
          held_bits = 7'(acc) & 7'((8'd1 << n) - 8'd1);
          held_count = n;
        end
        hcbp_pkg::OP_FLUSH: begin
          r.last = 1'b1;
          if (held_count > 0) begin
            r.pad_bits = hcbp_pkg::PAD_W'(8 - held_count);
            r.out_byte = hcbp_pkg::BYTE_W'(held_bits) << (8 - held_count);
            r.byte_valid = 1'b1;
          end
          held_bits = '0;
          held_count = 0;
          expected_outputs.push_back(r);
        end
        default: ;
      endcase
    endtask

    task compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(input packed_result_t got);
      packed_result_t want;
      if (expected_outputs.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got));
      end else begin
        want = expected_outputs.pop_front();
        compare_field("out_byte", got.out_byte, want.out_byte);
        compare_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
        compare_field("pad_bits", 8'(got.pad_bits), 8'(want.pad_bits));
        compare_field("error", 8'(got.error), 8'(want.error));
        compare_field("last", 8'(got.last), 8'(want.last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;

  bit_packer_predictor packer_model = new();

  hcbp_cmd_if cmd_ch ();
  hcbp_res_if res_ch ();

  huffman_code_bit_packer_unit i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = hcbp_pkg::OP_FLUSH;
    cmd_ch.symbol = '0;
    cmd_ch.code_bits = '0;
    cmd_ch.code_length = '0;
    res_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    res_ch.ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  // result side: check every transfer
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      packer_model.check_result('{res_ch.out_byte, res_ch.byte_valid, res_ch.pad_bits,
                                  res_ch.error, res_ch.last});
  end

  task automatic send_cmd(input logic [hcbp_pkg::OPCODE_W-1:0] op,
                          input logic [hcbp_pkg::SYMBOL_W-1:0] sym,
                          input logic [hcbp_pkg::CODE_W-1:0] code,
                          input logic [hcbp_pkg::LEN_W-1:0] len);
    cmd_item_t item;
    item = '{op, sym, code, len};
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.opcode <= op;
    cmd_ch.symbol <= sym;
    cmd_ch.code_bits <= code;
    cmd_ch.code_length <= len;
    do @(posedge clk); while (!cmd_ch.ready);
    packer_model.note_command(item);
  endtask

  // hold off the sender until every expected result is out
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (packer_model.pending() != 0);
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input int n_items);
    int counted;
    int unsigned roll;
    logic [hcbp_pkg::SYMBOL_W-1:0] sym;
    logic [hcbp_pkg::LEN_W-1:0] len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    counted = 0;
    while (counted < n_items) begin
      roll = $urandom_range(99);
      if (packer_model.loaded_syms.size() == 0 || roll < 22) begin
        len = ($urandom_range(3) == 0) ? hcbp_pkg::LEN_W'($urandom_range(20, 13))
                                       : hcbp_pkg::LEN_W'($urandom_range(12, 0));
        send_cmd(hcbp_pkg::OP_LOAD, hcbp_pkg::SYMBOL_W'($urandom_range(255)),
                 hcbp_pkg::CODE_W'($urandom()), len);
        counted++;
      end else if (roll < 80) begin
        sym = packer_model.loaded_syms[$urandom_range(packer_model.loaded_syms.size() - 1)];
        send_cmd(hcbp_pkg::OP_ENCODE, sym, hcbp_pkg::CODE_W'($urandom()),
                 hcbp_pkg::LEN_W'($urandom()));
        counted++;
      end else if (roll < 91) begin
        send_cmd(hcbp_pkg::OP_FLUSH, hcbp_pkg::SYMBOL_W'($urandom()),
                 hcbp_pkg::CODE_W'($urandom()), hcbp_pkg::LEN_W'($urandom()));
        counted++;
      end else if (roll < 95) begin
        send_cmd(OP_UNUSED, hcbp_pkg::SYMBOL_W'($urandom()),
                 hcbp_pkg::CODE_W'($urandom()), hcbp_pkg::LEN_W'($urandom()));
      end else begin
        send_cmd(hcbp_pkg::OP_LOAD, hcbp_pkg::SYMBOL_W'($urandom_range(255)),
                 hcbp_pkg::CODE_W'($urandom()),
                 hcbp_pkg::LEN_W'($urandom_range(31, hcbp_pkg::LEN_LIMIT + 1)));
        counted++;
      end
      if ($urandom_range(49) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 17;
    rx_idle_pct = 64;
    send_cmd(hcbp_pkg::OP_FLUSH, 8'h00, 20'h00000, 5'd0);    // nothing held
    send_cmd(hcbp_pkg::OP_LOAD, 8'h00, 20'hFFFFF, 5'd1);     // bits above length masked
    send_cmd(hcbp_pkg::OP_LOAD, 8'hFF, 20'hFFFFF, 5'd20);    // longest legal code
    send_cmd(hcbp_pkg::OP_LOAD, 8'h07, 20'hABCDE, 5'd0);     // zero-length code
    send_cmd(hcbp_pkg::OP_LOAD, 8'h03, 20'h12345, 5'd21);    // just over the limit
    send_cmd(hcbp_pkg::OP_LOAD, 8'h04, 20'hFFFFF, 5'd31);    // largest length field
    send_cmd(hcbp_pkg::OP_LOAD, 8'h05, 20'h00055, 5'd7);
    send_cmd(hcbp_pkg::OP_LOAD, 8'h06, 20'h000A5, 5'd8);
    send_cmd(hcbp_pkg::OP_ENCODE, 8'h07, 20'h00000, 5'd0);   // no byte out
    send_cmd(hcbp_pkg::OP_ENCODE, 8'h00, 20'hFFFFF, 5'd31);
    send_cmd(hcbp_pkg::OP_FLUSH, 8'hFF, 20'hFFFFF, 5'd31);   // seven pad bits
    send_cmd(hcbp_pkg::OP_ENCODE, 8'h05, 20'h00000, 5'd0);   // seven bits held
    send_cmd(hcbp_pkg::OP_ENCODE, 8'hFF, 20'h00000, 5'd0);   // three bytes at once
    send_cmd(hcbp_pkg::OP_FLUSH, 8'h00, 20'h00000, 5'd0);
    send_cmd(hcbp_pkg::OP_ENCODE, 8'h06, 20'h00000, 5'd0);   // exactly one byte
    send_cmd(hcbp_pkg::OP_FLUSH, 8'h00, 20'h00000, 5'd0);
    send_cmd(OP_UNUSED, 8'hFF, 20'hFFFFF, 5'd31);
    send_cmd(hcbp_pkg::OP_ENCODE, 8'h05, 20'h00000, 5'd0);
    send_cmd(hcbp_pkg::OP_ENCODE, 8'h00, 20'h00000, 5'd0);   // byte boundary
    send_cmd(hcbp_pkg::OP_LOAD, 8'h00, 20'h00000, 5'd20);    // overwrite an entry
    send_cmd(hcbp_pkg::OP_ENCODE, 8'h00, 20'h00000, 5'd0);
    send_cmd(hcbp_pkg::OP_LOAD, 8'h03, 20'h12345, 5'd20);    // entry after a failed load
    send_cmd(hcbp_pkg::OP_ENCODE, 8'h03, 20'h00000, 5'd0);
    send_cmd(hcbp_pkg::OP_FLUSH, 8'h00, 20'h00000, 5'd0);
    wait_drained();

    run_random_phase(17, 64, 80);
    wait_drained();
    run_random_phase(64, 17, 80);
    run_random_phase(0, 0, 80);

    cmd_ch.valid <= 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (packer_model.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (packer_model.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_if.sv
hw/rtl/hcbp_code_table.sv
hw/rtl/huffman_code_bit_packer_unit.sv
tb/sv/huffman_code_bit_packer_unit_tb.sv
